### src/cfb_pkg.sv
// Shared types and constants for the command frame builder.
// No dependencies; imported by cfb_front, cfb_back and the top level.
package cfb_pkg;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_HEAD   = 2'd0;
  localparam logic [1:0] REG_TAIL   = 2'd1;
  localparam logic [1:0] REG_SOURCE = 2'd2;
  localparam logic [1:0] REG_TARGET = 2'd3;

  localparam logic [7:0] HEAD_RESET = 8'h24;

  // Configuration values seen by the serializer
  typedef struct packed {
    logic [7:0] head;
    logic [7:0] tail;
    logic [7:0] source;
    logic [7:0] target;
  } cfg_t;

  // One classified input item, queued between front and back
  typedef struct packed {
    logic        first;        // frame start: header bytes go out first
    logic        has_payload;  // data byte goes out
    logic        trailer;      // checksum and tail close the frame
    logic [7:0]  data;
    logic [15:0] len;          // payload count + 2, wraps at 16 bits
    logic [7:0]  cls;
    logic [7:0]  code;
  } desc_t;

endpackage

### src/cfb_queue.sv
// Small register FIFO between the classifier and the serializer.
// Generic width and depth; no package dependency.
module cfb_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] head_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign empty_o     = (count_q == '0);
  assign head_data_o = mem_q[rd_ptr_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### src/cfb_front.sv
// Input side: accepts items, tracks frame position, classifies each transfer.
// Depends on cfb_pkg (desc_t).
module cfb_front
  import cfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  payload_byte_i,
  input  logic [15:0] payload_length_i,
  input  logic [7:0]  command_class_i,
  input  logic [7:0]  command_code_i,
  input  logic        empty_frame_i,
  input  logic        q_full_i,
  output logic        push_o,
  output desc_t       desc_o
);

  logic        in_frame_q, in_frame_d;
  logic [15:0] remaining_q, remaining_d;
  logic        accept;
  logic [15:0] count;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign push_o     = accept;
  assign count      = empty_frame_i ? 16'd0 : payload_length_i;

  always_comb begin
    in_frame_d  = in_frame_q;
    remaining_d = remaining_q;
    desc_o.data = payload_byte_i;
    desc_o.len  = count + 16'd2;
    desc_o.cls  = command_class_i;
    desc_o.code = command_code_i;
    if (in_frame_q) begin
      desc_o.first       = 1'b0;
      desc_o.has_payload = 1'b1;
      desc_o.trailer     = (remaining_q == 16'd1);
    end else begin
      desc_o.first       = 1'b1;
      desc_o.has_payload = (count != 16'd0);
      desc_o.trailer     = (count == 16'd0) || (count == 16'd1);
    end
    if (accept) begin
      if (in_frame_q) begin
        remaining_d = remaining_q - 16'd1;
        in_frame_d  = (remaining_q != 16'd1);
      end else if (!desc_o.trailer) begin
        in_frame_d  = 1'b1;
        remaining_d = count - 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      remaining_q <= '0;
    end else begin
      in_frame_q  <= in_frame_d;
      remaining_q <= remaining_d;
    end
  end

endmodule

### src/cfb_back.sv
// Output side: serializes queued items into frame bytes with a running checksum.
// Depends on cfb_pkg (desc_t, cfg_t).
module cfb_back
  import cfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  desc_t      head_i,
  output logic       pop_o,
  input  cfg_t       cfg_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       end_of_frame_o
);

  typedef enum logic [3:0] {
    ST_HEAD0, ST_HEAD1, ST_SOURCE, ST_TARGET, ST_LEN_LO, ST_LEN_HI,
    ST_CLASS, ST_CODE, ST_PAYLOAD, ST_SUM, ST_TAIL
  } step_e;

  logic       busy_q, busy_d;
  step_e      step_q, step_d, cur_step, next_step;
  logic [7:0] sum_q, sum_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       eof_q, eof_d;
  logic       load, last;
  logic [7:0] sel_byte;
  logic       summed;

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign end_of_frame_o = eof_q;

  assign cur_step = busy_q ? step_q : (head_i.first ? ST_HEAD0 : ST_PAYLOAD);
  // output slot free or draining this cycle
  assign load     = ~q_empty_i & (~out_valid_q | ~out_stall_i);
  assign pop_o    = load & last;

  always_comb begin
    sel_byte  = head_i.data;
    summed    = 1'b1;
    last      = 1'b0;
    next_step = cur_step;
    case (cur_step)
      ST_HEAD0: begin
        sel_byte  = cfg_i.head;
        next_step = ST_HEAD1;
      end
      ST_HEAD1: begin
        sel_byte  = cfg_i.head;
        next_step = ST_SOURCE;
      end
      ST_SOURCE: begin
        sel_byte  = cfg_i.source;
        next_step = ST_TARGET;
      end
      ST_TARGET: begin
        sel_byte  = cfg_i.target;
        next_step = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        sel_byte  = head_i.len[7:0];
        next_step = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        sel_byte  = head_i.len[15:8];
        next_step = ST_CLASS;
      end
      ST_CLASS: begin
        sel_byte  = head_i.cls;
        next_step = ST_CODE;
      end
      ST_CODE: begin
        sel_byte  = head_i.code;
        next_step = head_i.has_payload ? ST_PAYLOAD : ST_SUM;
      end
      ST_PAYLOAD: begin
        sel_byte  = head_i.data;
        next_step = ST_SUM;
        last      = ~head_i.trailer;
      end
      ST_SUM: begin
        sel_byte  = sum_q;
        summed    = 1'b0;
        next_step = ST_TAIL;
      end
      ST_TAIL: begin
        sel_byte  = cfg_i.tail;
        summed    = 1'b0;
        last      = 1'b1;
      end
      default: begin
        summed = 1'b0;
        last   = 1'b1;
      end
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_byte_d  = out_byte_q;
    eof_d       = eof_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = sel_byte;
      eof_d       = (cur_step == ST_TAIL);
      busy_d      = ~last;
      step_d      = next_step;
      if (cur_step == ST_HEAD0) begin
        sum_d = sel_byte;
      end else if (summed) begin
        sum_d = sum_q + sel_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= ST_HEAD0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      eof_q       <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      eof_q       <= eof_d;
    end
  end

endmodule

### src/command_frame_builder_core.sv
// Top level of the command frame builder: register port, classifier, queue, serializer.
// Depends on cfb_pkg, cfb_front, cfb_queue and cfb_back.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+------------------------------------------
//  input     | in        | in_valid_i/in_stall_o | payload_byte, payload_length, class, code,
//            |           |                       | empty_frame
//  output    | out       | out_valid_o/out_stall_i | out_byte, end_of_frame
//  config    | in        | APB psel/penable      | head, tail, source, target (addr 4*i)
//
// One output byte per cycle while out_stall_i is low; a frame's first item yields 9 to 11
// bytes, later items 1 or 3. Payload items stream in at one per cycle while the queue is
// not full; the serializer's single byte slot sets the rate. An item is written to the queue,
// then read from its head straight into the output register when the serializer is idle.
// Reset clears frame position, queue and output valid; registers return to their defaults.
// Input stalls only when the queue (QUEUE_DEPTH items) is full, e.g. during header bursts.
module command_frame_builder_core
  import cfb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  payload_byte_i,
  input  logic [15:0] payload_length_i,
  input  logic [7:0]  command_class_i,
  input  logic [7:0]  command_code_i,
  input  logic        empty_frame_i,
  // result bytes
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        end_of_frame_o
);

  cfg_t  cfg_q, cfg_d;
  logic  wr_en;
  logic  push, pop, q_full, q_empty;
  desc_t push_desc, head_desc;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        REG_HEAD:   cfg_d.head   = pwdata[7:0];
        REG_TAIL:   cfg_d.tail   = pwdata[7:0];
        REG_SOURCE: cfg_d.source = pwdata[7:0];
        REG_TARGET: cfg_d.target = pwdata[7:0];
        default:    cfg_d        = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HEAD:   prdata = {24'd0, cfg_q.head};
      REG_TAIL:   prdata = {24'd0, cfg_q.tail};
      REG_SOURCE: prdata = {24'd0, cfg_q.source};
      REG_TARGET: prdata = {24'd0, cfg_q.target};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head   <= HEAD_RESET;
      cfg_q.tail   <= '0;
      cfg_q.source <= '0;
      cfg_q.target <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cfb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .payload_byte_i   (payload_byte_i),
    .payload_length_i (payload_length_i),
    .command_class_i  (command_class_i),
    .command_code_i   (command_code_i),
    .empty_frame_i    (empty_frame_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .desc_o           (push_desc)
  );

  cfb_queue #(
    .Width ($bits(desc_t)),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .pop_i       (pop),
    .head_data_o (head_desc),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  cfb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .head_i         (head_desc),
    .pop_o          (pop),
    .cfg_i          (cfg_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule

### sim/command_frame_builder_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for command_frame_builder_core: drives frames and APB writes,
// predicts every serialized byte and checks it. Depends on cfb_pkg and the block's RTL.
module command_frame_builder_core_tb;
  import cfb_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 80;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  // Tracks frame position and checksum, and holds the bytes still owed by the block.
  class frame_scoreboard;
    cfg_t        regs;
    bit          in_frame;
    logic [15:0] bytes_left;
    logic [7:0]  checksum;
    frame_byte_t expected_bytes[$];
    int          errors;

    function new();
      regs.head  = HEAD_RESET;
      regs.tail  = 8'h00;
      regs.source = 8'h00;
      regs.target = 8'h00;
      in_frame   = 1'b0;
      bytes_left = '0;
      checksum   = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] value);
      case (idx)
        REG_HEAD:   regs.head = value;
        REG_TAIL:   regs.tail = value;
        REG_SOURCE: regs.source = value;
        REG_TARGET: regs.target = value;
        default: ;
      endcase
    endfunction

    function void push_byte(logic [7:0] value, logic last);
      frame_byte_t b;
      b.value = value;
      b.last  = last;
      expected_bytes.push_back(b);
    endfunction

    function void push_summed(logic [7:0] value);
      checksum += value;
      push_byte(value, 1'b0);
    endfunction

    function void close_frame();
      push_byte(checksum, 1'b0);
      push_byte(regs.tail, 1'b1);
      in_frame   = 1'b0;
      bytes_left = '0;
      checksum   = '0;
    endfunction

    // Expected bytes for one accepted input transfer.
    function void note_transfer(logic [7:0] data, logic [15:0] count, logic [7:0] cls,
                                logic [7:0] code, logic empty);
      logic [15:0] n;
      logic [15:0] frame_len;
      if (in_frame) begin
        push_summed(data);
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) close_frame();
        return;
      end
      n = empty ? 16'd0 : count;
      frame_len = n + 16'd2;   // wraps for lengths above range
      checksum = '0;
      push_summed(regs.head);
      push_summed(regs.head);
      push_summed(regs.source);
      push_summed(regs.target);
      push_summed(frame_len[7:0]);
      push_summed(frame_len[15:8]);
      push_summed(cls);
      push_summed(code);
      if (n == 16'd0) begin
        close_frame();
        return;
      end
      push_summed(data);
      if (n == 16'd1) begin
        close_frame();
        return;
      end
      in_frame   = 1'b1;
      bytes_left = n - 16'd1;
    endfunction

    function void check_byte(logic [7:0] value, logic last);
      frame_byte_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual out_byte %02h end_of_frame %0b",
                 $time, value, last);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (want.value !== value) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.value, value);
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: end_of_frame expected %0b actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  payload_byte_i;
  logic [15:0] payload_length_i;
  logic [7:0]  command_class_i;
  logic [7:0]  command_code_i;
  logic        empty_frame_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        end_of_frame_o;

  frame_scoreboard sb;
  bit idle_on = 1'b1;
  int sent_items = 0;
  int stall_left = 0;
  int cycle_count = 0;

  command_frame_builder_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .payload_byte_i   (payload_byte_i),
    .payload_length_i (payload_length_i),
    .command_class_i  (command_class_i),
    .command_code_i   (command_code_i),
    .empty_frame_i    (empty_frame_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .end_of_frame_o   (end_of_frame_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver backpressure in short random bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_transfer(payload_byte_i, payload_length_i, command_class_i,
                         command_code_i, empty_frame_i);
      if (out_valid_o && !out_stall_i)
        sb.check_byte(out_byte_o, end_of_frame_o);
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] head, input logic [7:0] tail,
                            input logic [7:0] source, input logic [7:0] target);
    apb_write(REG_HEAD, head);
    apb_write(REG_TAIL, tail);
    apb_write(REG_SOURCE, source);
    apb_write(REG_TARGET, target);
  endtask

  // One input transfer, optionally preceded by a random idle burst
  task automatic send_item(input logic [7:0] data, input logic [15:0] count,
                           input logic [7:0] cls, input logic [7:0] code, input logic empty);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    payload_byte_i   <= data;
    payload_length_i <= count;
    command_class_i  <= cls;
    command_code_i   <= code;
    empty_frame_i    <= empty;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
  endtask

  // Payload item with noise in the fields that only a frame start reads
  task automatic send_payload(input int fill);
    send_item(fill < 0 ? 8'($urandom_range(0, 255)) : fill[7:0],
              16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_frame(input logic [15:0] count, input logic empty,
                            input logic [7:0] cls, input logic [7:0] code, input int fill);
    int items;
    items = (empty || count == 16'd0) ? 1 : int'(count);
    send_item(fill < 0 ? 8'($urandom_range(0, 255)) : fill[7:0], count, cls, code, empty);
    for (int i = 1; i < items; i++) send_payload(fill);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_frame();
    int r;
    logic [15:0] count;
    logic empty;
    r = $urandom_range(0, 99);
    empty = 1'b0;
    if (r < 8) begin
      empty = 1'b1;
      count = 16'($urandom_range(0, 65535));
    end else if (r < 14) begin
      count = 16'd0;
    end else if (r < 22) begin
      count = 16'd1;
    end else if (r < 88) begin
      count = 16'($urandom_range(2, 12));
    end else begin
      count = 16'($urandom_range(13, 48));
    end
    send_frame(count, empty, pick_byte(), pick_byte(), -1);
  endtask

  initial begin
    int target;
    sb = new();
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_valid_i       = 1'b0;
    payload_byte_i   = '0;
    payload_length_i = '0;
    command_class_i  = '0;
    command_code_i   = '0;
    empty_frame_i    = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values; empty request ignores length, zero length acts as empty
    send_frame(16'hBEEF, 1'b1, 8'h00, 8'h00, -1);
    send_frame(16'd0, 1'b0, 8'hFF, 8'hFF, -1);
    send_frame(16'd1, 1'b0, 8'h5A, 8'hA5, 255);
    send_frame(16'd2, 1'b0, 8'h01, 8'h80, 0);
    send_frame(16'd3, 1'b0, 8'hC0, 8'h03, -1);
    wait_drained();
    set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_frame(16'hFFFF, 1'b1, 8'hFF, 8'h00, -1);
    send_frame(16'd1, 1'b0, 8'h00, 8'h00, 0);
    send_frame(16'd4, 1'b0, 8'hFF, 8'hFF, 255);
    wait_drained();
    set_config(8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(16'd0, 1'b0, 8'h33, 8'hCC, -1);
    send_frame(16'd2, 1'b0, 8'h00, 8'hFF, 255);
    // registers change in the middle of a frame: tail takes the new value
    send_item(8'h11, 16'd5, 8'h22, 8'h44, 1'b0);
    send_payload(-1);
    send_payload(-1);
    wait_drained();
    apb_write(REG_TAIL, 8'hC3);
    apb_write(REG_HEAD, 8'h7E);
    send_payload(-1);
    send_payload(-1);
    send_frame(16'd1, 1'b0, 8'h0F, 8'hF0, -1);

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      set_config(pick_byte(), pick_byte(), pick_byte(), pick_byte());
      if (phase == 3) idle_on = 1'b0;
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) random_frame();
    end

    // Length above range: field wraps; that frame is still open when the run ends
    wait_drained();
    set_config(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    send_frame(16'd3, 1'b0, pick_byte(), pick_byte(), -1);
    send_item(pick_byte(), 16'hFFFE, pick_byte(), pick_byte(), 1'b0);
    repeat (4) send_payload(-1);

    wait_drained();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
